// ===== src/apvsc_pkg.sv =====
// ----------------------------------------------------------------------------
// apvsc_pkg
// Shared types and constants for the accelerometer step counter.
// ----------------------------------------------------------------------------
package apvsc_pkg;

    localparam int COUNT_WIDTH_DEF = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PEAK_LEVEL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_MARGIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd3;

    localparam logic [14:0] PEAK_LEVEL_RST    = 15'd8000;
    localparam logic [14:0] NOISE_MARGIN_RST  = 15'd2000;
    localparam logic [15:0] MIN_INTERVAL_RST  = 16'd100;
    localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd100;

    localparam logic [14:0] SQRT_TOP = 15'h7FFF;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } t_in;

    typedef struct packed {
        logic [31:0] total_steps;
        logic        step_seen;
        logic [14:0] magnitude;
    } t_out;

    typedef struct packed {
        logic       load;
        logic       sq_en;
        logic [1:0] sq_sel;
        logic       root_en;
        logic       commit;
    } t_cmd;

    typedef struct packed {
        logic root_done;
    } t_stat;

endpackage

// ===== src/apvsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// apvsc_ctrl
// Sequencer for one sample: three squares, the root search and the update.
// ----------------------------------------------------------------------------
module apvsc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    output apvsc_pkg::t_cmd o_cmd,
    input  apvsc_pkg::t_stat i_stat
);
    import apvsc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ_X,
        S_SQ_Y,
        S_SQ_Z,
        S_ROOT,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_commit;

    assign w_commit = (r_state == S_FIN) && (!r_out_valid || !i_stall);

    always_comb begin
        o_cmd         = '0;
        o_cmd.load    = (r_state == S_IDLE) && i_valid;
        o_cmd.root_en = (r_state == S_ROOT) && !i_stat.root_done;
        o_cmd.commit  = w_commit;
        unique case (r_state)
            S_SQ_X: begin
                o_cmd.sq_en  = 1'b1;
                o_cmd.sq_sel = AXIS_X;
            end
            S_SQ_Y: begin
                o_cmd.sq_en  = 1'b1;
                o_cmd.sq_sel = AXIS_Y;
            end
            S_SQ_Z: begin
                o_cmd.sq_en  = 1'b1;
                o_cmd.sq_sel = AXIS_Z;
            end
            default: begin
                o_cmd.sq_en  = 1'b0;
                o_cmd.sq_sel = AXIS_X;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_SQ_X;
            S_SQ_X: n_state = S_SQ_Y;
            S_SQ_Y: n_state = S_SQ_Z;
            S_SQ_Z: n_state = S_ROOT;
            S_ROOT: if (i_stat.root_done) n_state = S_FIN;
            S_FIN:  if (w_commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase

        n_out_valid = r_out_valid;
        if (w_commit) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ===== src/apvsc_dp.sv =====
// ----------------------------------------------------------------------------
// apvsc_dp
// Datapath: shared multiplier, square sum, root search, detector state and
// configuration registers.
// ----------------------------------------------------------------------------
module apvsc_dp #(
    parameter int COUNT_WIDTH = apvsc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  apvsc_pkg::t_in                    i_in,
    input  apvsc_pkg::t_cmd                   i_cmd,
    output apvsc_pkg::t_stat                  o_stat,
    output apvsc_pkg::t_out                   o_out,
    input  logic                              i_cfg_we,
    input  logic [apvsc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [apvsc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import apvsc_pkg::*;

    logic [14:0] r_peak_level;
    logic [14:0] r_noise_margin;
    logic [15:0] r_min_interval;
    logic [15:0] r_sample_period;

    logic [15:0] r_ax;
    logic [15:0] r_ay;
    logic [15:0] r_az;
    logic [31:0] r_sum;
    logic [14:0] r_lo;
    logic [14:0] r_hi;

    logic [14:0]            r_prev;
    logic                   r_awaiting;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [31:0]            r_time;
    logic [31:0]            r_last;
    t_out                   r_out;

    logic [15:0] w_axis;
    logic [15:0] w_abs;
    logic [15:0] w_mid_sum;
    logic [14:0] w_mid;
    logic [15:0] w_mul_a;
    logic [31:0] w_prod;

    logic signed [16:0] w_fall;
    logic signed [16:0] w_rise;
    logic signed [16:0] w_noise;
    logic [31:0]        w_time;
    logic [31:0]        w_elapsed;
    logic               w_is_fall;
    logic               w_is_rise;
    logic               w_count_ok;
    logic               w_step;
    logic [COUNT_WIDTH-1:0]    w_count_next;
    logic [COUNT_WIDTH+31:0]   w_count_ext;

    always_comb begin
        unique case (i_cmd.sq_sel)
            AXIS_X:  w_axis = r_ax;
            AXIS_Y:  w_axis = r_ay;
            AXIS_Z:  w_axis = r_az;
            default: w_axis = r_ax;
        endcase
    end

    assign w_abs     = w_axis[15] ? (~w_axis + 16'd1) : w_axis;
    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = w_mid_sum[15:1];
    assign w_mul_a   = i_cmd.root_en ? {1'b0, w_mid} : w_abs;
    assign w_prod    = w_mul_a * w_mul_a;

    assign o_stat.root_done = ((r_hi - r_lo) <= 15'd1);

    assign w_fall     = $signed({2'b00, r_prev}) - $signed({2'b00, r_lo});
    assign w_rise     = $signed({2'b00, r_lo}) - $signed({2'b00, r_prev});
    assign w_noise    = $signed({2'b00, r_noise_margin});
    assign w_time     = r_time + {16'd0, r_sample_period};
    assign w_elapsed  = w_time - r_last;
    assign w_is_fall  = (w_fall > w_noise) && (r_prev > r_peak_level);
    assign w_is_rise  = (w_rise > w_noise);
    assign w_count_ok = (w_elapsed > {16'd0, r_min_interval});
    assign w_step     = r_awaiting && w_is_rise && w_count_ok;
    assign w_count_next = w_step ? (r_count + COUNT_WIDTH'(1)) : r_count;
    assign w_count_ext  = {32'd0, w_count_next};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_level    <= PEAK_LEVEL_RST;
            r_noise_margin  <= NOISE_MARGIN_RST;
            r_min_interval  <= MIN_INTERVAL_RST;
            r_sample_period <= SAMPLE_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PEAK_LEVEL:    r_peak_level    <= i_cfg_data[14:0];
                REG_NOISE_MARGIN:  r_noise_margin  <= i_cfg_data[14:0];
                REG_MIN_INTERVAL:  r_min_interval  <= i_cfg_data;
                REG_SAMPLE_PERIOD: r_sample_period <= i_cfg_data;
                default:           r_peak_level    <= r_peak_level;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_awaiting <= 1'b0;
            r_count    <= '0;
            r_time     <= '0;
            r_last     <= '0;
        end else if (i_cmd.commit) begin
            r_prev  <= r_lo;
            r_count <= w_count_next;
            r_time  <= w_time;
            if (w_step) begin
                r_last <= w_time;
            end
            if (!r_awaiting) begin
                if (w_is_fall) r_awaiting <= 1'b1;
            end else begin
                if (w_is_rise) r_awaiting <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax  <= i_in.accel_x;
            r_ay  <= i_in.accel_y;
            r_az  <= i_in.accel_z;
            r_sum <= '0;
            r_lo  <= '0;
            r_hi  <= SQRT_TOP;
        end else if (i_cmd.sq_en) begin
            r_sum <= r_sum + w_prod;
        end else if (i_cmd.root_en) begin
            if (w_prod <= r_sum) begin
                r_lo <= w_mid;
            end else begin
                r_hi <= w_mid;
            end
        end
        if (i_cmd.commit) begin
            r_out.total_steps <= w_count_ext[31:0];
            r_out.step_seen   <= w_step;
            r_out.magnitude   <= r_lo;
        end
    end

    assign o_out = r_out;

endmodule

// ===== src/accel_peak_valley_step_counter.sv =====
// ----------------------------------------------------------------------------
// accel_peak_valley_step_counter
// Peak and valley step detector on the magnitude of a three-axis sample.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------
//   sample  | in        | i_valid / o_stall  | i_in  (accel_x, accel_y, accel_z)
//   result  | out       | o_valid / i_stall  | o_out (total_steps, step_seen,
//           |           |                    |        magnitude)
//   config  | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// A sample is taken in, then squared in three squares on the shared
// multiplier, then its root is searched on the multiplier step by step as
// the search path decides; once the search reports done, the detector is
// updated and the result register loaded, after any held result is taken.
// A finished result waits in the output register while the next sample runs.
// Reset is synchronous and restores the register defaults and a zero count.
// ----------------------------------------------------------------------------
module accel_peak_valley_step_counter #(
    parameter int COUNT_WIDTH = apvsc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  apvsc_pkg::t_in                   i_in,
    input  logic                             i_valid,
    output logic                             o_stall,
    output apvsc_pkg::t_out                  o_out,
    output logic                             o_valid,
    input  logic                             i_stall,
    input  logic                             i_cfg_we,
    input  logic [apvsc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [apvsc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import apvsc_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    apvsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    apvsc_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

endmodule

// ===== tb/sv/tb_accel_peak_valley_step_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accel_peak_valley_step_counter
// Self-checking bench for the accelerometer peak and valley step counter.
//
// Samples go in on the valid/stall channel. A local detector model predicts
// the magnitude, step flag and step count of each sample, and every result
// is compared field by field in order. Tests cover the magnitude extremes,
// the swing and peak thresholds, register extremes, random vectors and
// gait-like sequences, a long output stall and the longest sample period.
// ----------------------------------------------------------------------------
module tb_accel_peak_valley_step_counter;
    import apvsc_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    t_in                   i_in;
    logic                  i_valid;
    logic                  o_stall;
    t_out                  o_out;
    logic                  o_valid;
    logic                  i_stall;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    logic [14:0] peak_cfg   = PEAK_LEVEL_RST;
    logic [14:0] noise_cfg  = NOISE_MARGIN_RST;
    logic [15:0] min_cfg    = MIN_INTERVAL_RST;
    logic [15:0] period_cfg = SAMPLE_PERIOD_RST;

    logic [14:0] prev_mag     = '0;
    logic        in_valley    = 1'b0;
    logic [31:0] step_count   = '0;
    logic [31:0] clock_ms     = '0;
    logic [31:0] last_step_ms = '0;

    t_out pending_steps[$];

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_hold    = 0;
    int rx_left    = 0;
    int n_sent     = 0;
    int n_checked  = 0;
    int n_steps    = 0;
    int n_fail     = 0;

    accel_peak_valley_step_counter u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .o_out      (o_out),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [14:0] root_of(input longint sq);
        logic [16:0] r;
        logic [16:0] t;
        r = '0;
        for (int b = 15; b >= 0; b--) begin
            t = r | (17'd1 << b);
            if (longint'(t) * longint'(t) <= sq) r = t;
        end
        if (r > 17'd32766) r = 17'd32766;
        return r[14:0];
    endfunction

    function automatic t_out advance_detector(input t_in s);
        t_out   r;
        longint xl, yl, zl;
        int     cur, prev, nm;
        xl = s.accel_x;
        yl = s.accel_y;
        zl = s.accel_z;
        r.magnitude = root_of(xl * xl + yl * yl + zl * zl);
        r.step_seen = 1'b0;
        cur  = int'(r.magnitude);
        prev = int'(prev_mag);
        nm   = int'(noise_cfg);
        clock_ms = clock_ms + period_cfg;
        if (!in_valley) begin
            if (cur < prev - nm && prev > int'(peak_cfg)) in_valley = 1'b1;
        end else if (cur > prev + nm) begin
            if (clock_ms - last_step_ms > {16'd0, min_cfg}) begin
                step_count   = step_count + 1;
                last_step_ms = clock_ms;
                r.step_seen  = 1'b1;
            end
            in_valley = 1'b0;
        end
        prev_mag      = r.magnitude;
        r.total_steps = step_count;
        return r;
    endfunction

    function automatic t_in vec(input int x, input int y, input int z);
        t_in s;
        s.accel_x = 16'(x);
        s.accel_y = 16'(y);
        s.accel_z = 16'(z);
        return s;
    endfunction

    function automatic t_in sample_at(input int mag);
        int a, b, m;
        m = (mag > 32767) ? 32767 : mag;
        if ($urandom_range(0, 1) != 0) m = -m;
        a = int'($urandom_range(0, 200)) - 100;
        b = int'($urandom_range(0, 200)) - 100;
        case (2'($urandom_range(0, 2)))
            AXIS_X: return vec(m, a, b);
            AXIS_Y: return vec(a, m, b);
            default: return vec(a, b, m);
        endcase
    endfunction

    function automatic t_in noise_sample();
        t_in s;
        s.accel_x = 16'($urandom);
        s.accel_y = 16'($urandom);
        s.accel_z = 16'($urandom);
        return s;
    endfunction

    task automatic send_sample(input t_in s);
        int gap;
        gap = tx_idle_on ? idle_len() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in    = s;
        i_valid = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_steps.push_back(advance_detector(s));
        n_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_steps.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        unique case (idx)
            REG_PEAK_LEVEL:    peak_cfg   = data[14:0];
            REG_NOISE_MARGIN:  noise_cfg  = data[14:0];
            REG_MIN_INTERVAL:  min_cfg    = data;
            REG_SAMPLE_PERIOD: period_cfg = data;
        endcase
    endtask

    task automatic apply_regs(input logic [15:0] pk, input logic [15:0] nm,
                              input logic [15:0] mi, input logic [15:0] sp);
        write_reg(REG_PEAK_LEVEL, pk);
        write_reg(REG_NOISE_MARGIN, nm);
        write_reg(REG_MIN_INTERVAL, mi);
        write_reg(REG_SAMPLE_PERIOD, sp);
    endtask

    // Gait-like input: runs of high magnitudes and runs of low ones, with an
    // occasional random vector that breaks the pattern.
    task automatic send_walk(input int n_items, input int low_top);
        int left, k;
        left = n_items;
        while (left > 0) begin
            if ($urandom_range(0, 9) == 0) begin
                send_sample(noise_sample());
                left--;
            end else begin
                k = $urandom_range(1, 3);
                repeat (k) if (left > 0) begin
                    send_sample(sample_at($urandom_range(20000, 32767)));
                    left--;
                end
                k = $urandom_range(1, 3);
                repeat (k) if (left > 0) begin
                    send_sample(sample_at($urandom_range(0, low_top)));
                    left--;
                end
            end
        end
    endtask

    task automatic run_setting(input logic [15:0] pk, input logic [15:0] nm,
                               input logic [15:0] mi, input logic [15:0] sp);
        apply_regs(pk, nm, mi, sp);
        send_walk(25, 8000);
        wait_idle();
    endtask

    task automatic test_directed();
        send_sample(vec(0, 0, 0));
        send_sample(vec(-32768, -32768, -32768));
        send_sample(vec(32767, 32767, 32767));
        send_sample(vec(-32768, 0, 0));
        send_sample(vec(0, 32767, 0));
        send_sample(vec(0, 0, 32766));
        send_sample(vec(32765, 0, 0));
        send_sample(vec(3, 4, 0));
        send_sample(vec(1, 1, 1));
        send_sample(vec(-1, -1, -1));
        send_sample(vec(2, -2, 2));
        // Falls and rises of exactly the noise margin do not count.
        send_sample(vec(12000, 0, 0));
        send_sample(vec(10000, 0, 0));
        send_sample(vec(0, 7999, 0));
        send_sample(vec(0, 0, 9999));
        send_sample(vec(12000, 0, 0));
        // A previous magnitude one above the peak level arms the detector.
        send_sample(vec(8000, 0, 0));
        send_sample(vec(0, 0, 0));
        send_sample(vec(0, -8001, 0));
        send_sample(vec(0, 0, 0));
        send_sample(vec(30000, 0, 0));
        wait_idle();
    endtask

    task automatic test_default_walk();
        send_walk(120, 6000);
        wait_idle();
    endtask

    task automatic test_register_sweep();
        run_setting(16'd0, 16'd0, 16'd0, 16'd0);
        run_setting(16'd0, 16'd0, 16'd0, 16'd1);
        run_setting(16'hFFFF, 16'd100, 16'd100, 16'd100);
        run_setting(16'h8000 | 16'd3000, 16'hFFFF, 16'd100, 16'd100);
        run_setting(16'd5000, 16'd500, 16'hFFFF, 16'd100);
        run_setting(16'd10000, 16'd3000, 16'd100, 16'd40);
        run_setting(16'd8000, 16'd2000, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_random_noise();
        apply_regs({1'b0, PEAK_LEVEL_RST}, {1'b0, NOISE_MARGIN_RST},
                   MIN_INTERVAL_RST, SAMPLE_PERIOD_RST);
        repeat (60) send_sample(noise_sample());
        wait_idle();
    endtask

    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_hold    = 300;
        send_walk(12, 6000);
        tx_idle_on = 1'b1;
        wait_idle();
    endtask

    // Walks back to back at the longest sample period, with the step
    // interval just below it.
    task automatic test_long_period();
        apply_regs(16'd8000, 16'd2000, 16'hFFFE, 16'hFFFF);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_walk(30, 6000);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        wait_idle();
    endtask

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                i_stall = 1'b1;
                rx_hold--;
            end else if (rx_left > 0) begin
                i_stall = 1'b1;
                rx_left--;
            end else begin
                i_stall = 1'b0;
                if (rx_idle_on) rx_left = idle_len();
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_steps.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, o_out);
                n_fail++;
            end else begin
                want = pending_steps.pop_front();
                n_checked++;
                if (o_out.step_seen) n_steps++;
                if (o_out.total_steps !== want.total_steps) begin
                    $display("%0t: total_steps expected %0d actual %0d",
                             $time, want.total_steps, o_out.total_steps);
                    n_fail++;
                end
                if (o_out.step_seen !== want.step_seen) begin
                    $display("%0t: step_seen expected %0d actual %0d",
                             $time, want.step_seen, o_out.step_seen);
                    n_fail++;
                end
                if (o_out.magnitude !== want.magnitude) begin
                    $display("%0t: magnitude expected %0d actual %0d",
                             $time, want.magnitude, o_out.magnitude);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_in       = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_PEAK_LEVEL;
        i_cfg_data = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_default_walk();
        test_register_sweep();
        test_random_noise();
        test_backpressure();
        test_long_period();
        $display("Checked %0d results for %0d samples; %0d of them counted a step.",
                 n_checked, n_sent, n_steps);
        $display("Covered saturation, swing thresholds, register extremes, stalls and long periods.");
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
